// ===== sv/isrf_pkg.sv =====
package isrf_pkg;

    // Register file geometry.
    localparam int ADDR_W = 8;
    localparam int DATA_W = 8;
    localparam int DEPTH  = 256;
    localparam int TIMER_W = 12;
    localparam int SRC_N  = 4;

    // Register offsets with side effects.
    localparam logic [ADDR_W-1:0] ADDR_INIT0     = 8'h90;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_EN    = 8'h92;
    localparam logic [ADDR_W-1:0] ADDR_FIRQ_EN   = 8'h93;
    localparam logic [ADDR_W-1:0] ADDR_TIMER_MSB = 8'h94;
    localparam logic [ADDR_W-1:0] ADDR_TIMER_LSB = 8'h95;

    // Value returned by reads of the timer registers.
    localparam logic [DATA_W-1:0] TIMER_READBACK = 8'd126;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_EVENT = 2'd2,
        REQ_IDLE  = 2'd3
    } t_req;

    // Interrupt source codes.
    typedef enum logic [1:0] {
        SRC_KEYBOARD   = 2'd0,
        SRC_VERTICAL   = 2'd1,
        SRC_HORIZONTAL = 2'd2,
        SRC_TIMER      = 2'd3
    } t_src;

    // Bit of a source in the enable registers and the latches.
    function automatic logic [DATA_W-1:0] source_bit(input t_src src);
        logic [DATA_W-1:0] b;
        unique case (src)
            SRC_KEYBOARD:   b = 8'h02;
            SRC_VERTICAL:   b = 8'h08;
            SRC_HORIZONTAL: b = 8'h10;
            SRC_TIMER:      b = 8'h20;
            default:        b = '0;
        endcase
        return b;
    endfunction

    // Source-enable mask from the OR of both enable registers.
    function automatic logic [SRC_N-1:0] enable_from(input logic [DATA_W-1:0] both);
        return {both[5], both[4], both[3], both[1]};
    endfunction

endpackage

// ===== sv/isrf_ram.sv =====
module isrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/interrupt_steering_register_file_core.sv =====
// Interrupt steering register file.
// Input channel (i_in_valid / o_in_ready) carries one request: a register
// read, a register write or an interrupt source event. Output channel
// (o_out_valid / i_out_ready) returns exactly one result for each request,
// in order.
// A request passes through the read stage (registered RAM read) and the
// output register. Throughput is one request per cycle unless stalled;
// the RAM port is used once per request.
// Reset clears the interrupt latches, the enhanced flags, the enable mask
// and the per-entry valid bits, so registers other than 0x92 to 0x95 read
// as zero until written; no clearing pass is needed and a request can be
// taken in the first cycle after reset.
// When the receiver stalls, the result waits in the output register while
// one more request is taken into the read stage; after that o_in_ready
// drops until the output is taken.
// Writes to 0x90, 0x92, 0x93 and 0x95 also update shadow registers used by
// the interrupt routing and the timer reload value.
module interrupt_steering_register_file_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_req_type,
    input  logic [isrf_pkg::ADDR_W-1:0]            i_reg_address,
    input  logic [isrf_pkg::DATA_W-1:0]            i_write_data,
    input  logic [1:0]                             i_event_source,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [isrf_pkg::DATA_W-1:0]            o_read_data,
    output logic                                   o_irq_assert,
    output logic                                   o_firq_assert,
    output logic                                   o_timer_load,
    output logic [isrf_pkg::TIMER_W-1:0]           o_timer_value,
    output logic [isrf_pkg::SRC_N-1:0]             o_source_enable
);

    import isrf_pkg::*;

    // Control state.
    logic [DEPTH-1:0]   r_valid;
    logic [DATA_W-1:0]  r_irq_latch,  n_irq_latch;
    logic [DATA_W-1:0]  r_firq_latch, n_firq_latch;
    logic               r_eirq,  n_eirq;
    logic               r_efirq, n_efirq;
    logic [SRC_N-1:0]   r_enable, n_enable;
    logic [DATA_W-1:0]  r_irq_en,  n_irq_en;
    logic [DATA_W-1:0]  r_firq_en, n_firq_en;
    logic [DATA_W-1:0]  r_timer_lsb, n_timer_lsb;
    logic               r_s1_valid;
    logic               r_out_valid;

    // Read-stage payload.
    logic               r_s1_use_mem, n_s1_use_mem;
    logic               r_s1_hit;
    logic [DATA_W-1:0]  r_s1_fixed, n_s1_fixed;
    logic               r_s1_irq, n_s1_irq;
    logic               r_s1_firq, n_s1_firq;
    logic               r_s1_tload, n_s1_tload;
    logic [TIMER_W-1:0] r_s1_tval, n_s1_tval;

    // Output payload.
    logic [DATA_W-1:0]  r_o_read_data;
    logic               r_o_irq;
    logic               r_o_firq;
    logic               r_o_tload;
    logic [TIMER_W-1:0] r_o_tval;
    logic [SRC_N-1:0]   r_o_enable;

    logic               accept;
    logic               advance;
    logic               ram_we;
    logic [DATA_W-1:0]  ram_rdata;
    logic [DATA_W-1:0]  s1_read_data;
    logic [DATA_W-1:0]  src_bit;
    t_req               req;

    assign req     = t_req'(i_req_type);
    assign src_bit = source_bit(t_src'(i_event_source));
    assign advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign accept  = i_in_valid && o_in_ready;
    assign ram_we  = accept && (req == REQ_WRITE);

    // Register storage; read every accepted request at its address.
    isrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_reg_address),
        .i_wdata (i_write_data),
        .i_re    (accept),
        .i_raddr (i_reg_address),
        .o_rdata (ram_rdata)
    );

    // Request decode: side effects and the parts of the result known at once.
    always_comb begin
        n_irq_latch  = r_irq_latch;
        n_firq_latch = r_firq_latch;
        n_eirq       = r_eirq;
        n_efirq      = r_efirq;
        n_irq_en     = r_irq_en;
        n_firq_en    = r_firq_en;
        n_timer_lsb  = r_timer_lsb;
        n_enable     = r_enable;
        n_s1_use_mem = 1'b0;
        n_s1_fixed   = '0;
        n_s1_irq     = 1'b0;
        n_s1_firq    = 1'b0;
        n_s1_tload   = 1'b0;
        n_s1_tval    = '0;
        unique case (req)
            REQ_READ: begin
                if (i_reg_address == ADDR_IRQ_EN) begin
                    n_s1_fixed  = r_irq_latch;
                    n_irq_latch = '0;
                end else if (i_reg_address == ADDR_FIRQ_EN) begin
                    n_s1_fixed   = r_firq_latch;
                    n_firq_latch = '0;
                end else if (i_reg_address == ADDR_TIMER_MSB ||
                             i_reg_address == ADDR_TIMER_LSB) begin
                    n_s1_fixed = TIMER_READBACK;
                end else begin
                    n_s1_use_mem = 1'b1;
                end
            end
            REQ_WRITE: begin
                if (i_reg_address == ADDR_INIT0) begin
                    n_efirq = i_write_data[4];
                    n_eirq  = i_write_data[5];
                end else if (i_reg_address == ADDR_IRQ_EN) begin
                    n_irq_en = i_write_data;
                    n_enable = enable_from(i_write_data | r_firq_en);
                end else if (i_reg_address == ADDR_FIRQ_EN) begin
                    n_firq_en = i_write_data;
                    n_enable  = enable_from(r_irq_en | i_write_data);
                end else if (i_reg_address == ADDR_TIMER_MSB) begin
                    n_s1_tload = 1'b1;
                    n_s1_tval  = {i_write_data[TIMER_W-DATA_W-1:0], r_timer_lsb};
                end else if (i_reg_address == ADDR_TIMER_LSB) begin
                    n_timer_lsb = i_write_data;
                end
            end
            REQ_EVENT: begin
                // Fast interrupt has priority over the normal one.
                if ((r_firq_en & src_bit) != '0 && r_efirq) begin
                    n_s1_firq    = 1'b1;
                    n_firq_latch = r_firq_latch | src_bit;
                end else if ((r_irq_en & src_bit) != '0 && r_eirq) begin
                    n_s1_irq    = 1'b1;
                    n_irq_latch = r_irq_latch | src_bit;
                end
            end
            REQ_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_irq_latch  <= '0;
            r_firq_latch <= '0;
            r_eirq       <= 1'b0;
            r_efirq      <= 1'b0;
            r_enable     <= '0;
            r_irq_en     <= '0;
            r_firq_en    <= '0;
            r_timer_lsb  <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_irq_latch  <= n_irq_latch;
                r_firq_latch <= n_firq_latch;
                r_eirq       <= n_eirq;
                r_efirq      <= n_efirq;
                r_enable     <= n_enable;
                r_irq_en     <= n_irq_en;
                r_firq_en    <= n_firq_en;
                r_timer_lsb  <= n_timer_lsb;
            end
            if (ram_we) begin
                r_valid[i_reg_address] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Read-stage payload, taken with the request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_use_mem <= n_s1_use_mem;
            r_s1_hit     <= r_valid[i_reg_address];
            r_s1_fixed   <= n_s1_fixed;
            r_s1_irq     <= n_s1_irq;
            r_s1_firq    <= n_s1_firq;
            r_s1_tload   <= n_s1_tload;
            r_s1_tval    <= n_s1_tval;
        end
    end

    // An entry never written reads as zero.
    assign s1_read_data = r_s1_use_mem ? (r_s1_hit ? ram_rdata : '0) : r_s1_fixed;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_read_data <= s1_read_data;
            r_o_irq       <= r_s1_irq;
            r_o_firq      <= r_s1_firq;
            r_o_tload     <= r_s1_tload;
            r_o_tval      <= r_s1_tval;
            r_o_enable    <= r_enable;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_o_read_data;
    assign o_irq_assert    = r_o_irq;
    assign o_firq_assert   = r_o_firq;
    assign o_timer_load    = r_o_tload;
    assign o_timer_value   = r_o_tval;
    assign o_source_enable = r_o_enable;

    // An event goes to one interrupt line at most.
    a_one_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_irq_assert && o_firq_assert))
        else $error("event routed to both interrupt lines");

    // A timer reload comes only from a write, never with read data or a route.
    a_tload_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timer_load) |->
            (o_read_data == '0 && !o_irq_assert && !o_firq_assert))
        else $error("timer reload mixed with another result");

    // The timer value is zero without the strobe.
    a_tval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_timer_load) |-> (o_timer_value == '0))
        else $error("timer value without reload strobe");

    // Reading the normal interrupt latch clears it.
    a_irq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req == REQ_READ && i_reg_address == ADDR_IRQ_EN)
            |=> (r_irq_latch == '0))
        else $error("IRQ latch not cleared by read");

endmodule

// ===== tb/sv/interrupt_steering_checker.sv =====
`timescale 1ns / 100ps

module interrupt_steering_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [isrf_pkg::ADDR_W-1:0]   i_reg_address,
    input  logic [isrf_pkg::DATA_W-1:0]   i_write_data,
    input  logic [1:0]                    i_event_source,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [isrf_pkg::DATA_W-1:0]   i_read_data,
    input  logic                          i_irq_assert,
    input  logic                          i_firq_assert,
    input  logic                          i_timer_load,
    input  logic [isrf_pkg::TIMER_W-1:0]  i_timer_value,
    input  logic [isrf_pkg::SRC_N-1:0]    i_source_enable,
    output int                            o_fail_count,
    output int                            o_pending
);
    import isrf_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               irq_assert;
        logic               firq_assert;
        logic               timer_load;
        logic [TIMER_W-1:0] timer_value;
        logic [SRC_N-1:0]   source_enable;
    } t_steer_result;

    // Mirror of the block's state.
    logic [DATA_W-1:0] reg_image [DEPTH];
    logic [DATA_W-1:0] irq_pending;
    logic [DATA_W-1:0] firq_pending;
    logic              enh_irq;
    logic              enh_firq;
    logic [SRC_N-1:0]  enable_mask;

    t_steer_result results_due[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    // Position of a source in the enable registers and the latches.
    function automatic logic [DATA_W-1:0] latch_bit(input t_src src);
        logic [SRC_N-1:0] one_hot;
        one_hot = 4'b0001 << src;
        return {2'b00, one_hot[3], one_hot[2], one_hot[1], 1'b0, one_hot[0], 1'b0};
    endfunction

    task automatic clear_model();
        for (int i = 0; i < DEPTH; i++) begin
            reg_image[i] = '0;
        end
        irq_pending  = '0;
        firq_pending = '0;
        enh_irq      = 1'b0;
        enh_firq     = 1'b0;
        enable_mask  = '0;
    endtask

    // Apply one request to the mirror and return the result it should produce.
    function automatic t_steer_result steer_request(input t_req req,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] data,
                                                    input t_src src);
        t_steer_result     r;
        logic [DATA_W-1:0] src_bit;
        logic [DATA_W-1:0] both;
        r = '0;
        src_bit = latch_bit(src);
        case (req)
            REQ_READ: begin
                if (addr == ADDR_IRQ_EN) begin
                    r.read_data = irq_pending;
                    irq_pending = '0;
                end else if (addr == ADDR_FIRQ_EN) begin
                    r.read_data  = firq_pending;
                    firq_pending = '0;
                end else if (addr == ADDR_TIMER_MSB || addr == ADDR_TIMER_LSB) begin
                    r.read_data = TIMER_READBACK;
                end else begin
                    r.read_data = reg_image[addr];
                end
            end
            REQ_WRITE: begin
                reg_image[addr] = data;
                if (addr == ADDR_INIT0) begin
                    enh_firq = data[4];
                    enh_irq  = data[5];
                end else if (addr == ADDR_IRQ_EN || addr == ADDR_FIRQ_EN) begin
                    both = reg_image[ADDR_IRQ_EN] | reg_image[ADDR_FIRQ_EN];
                    for (int s = 0; s < SRC_N; s++) begin
                        enable_mask[s] = |(both & latch_bit(t_src'(s)));
                    end
                end else if (addr == ADDR_TIMER_MSB) begin
                    r.timer_load  = 1'b1;
                    r.timer_value = {reg_image[ADDR_TIMER_MSB][3:0], reg_image[ADDR_TIMER_LSB]};
                end
            end
            REQ_EVENT: begin
                // The fast line wins when both routes would take the event.
                if ((reg_image[ADDR_FIRQ_EN] & src_bit) != '0 && enh_firq) begin
                    r.firq_assert = 1'b1;
                    firq_pending  = firq_pending | src_bit;
                end else if ((reg_image[ADDR_IRQ_EN] & src_bit) != '0 && enh_irq) begin
                    r.irq_assert = 1'b1;
                    irq_pending  = irq_pending | src_bit;
                end
            end
            default: ;
        endcase
        r.source_enable = enable_mask;
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endfunction

    // Compare each returned result with the oldest prediction, then predict
    // for the request taken at this edge.
    always @(posedge i_clk) begin
        t_steer_result want;
        if (!i_rst_n) begin
            clear_model();
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    $error("result returned with no request outstanding");
                end else begin
                    want = results_due.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(i_read_data));
                    check_field("irq_assert", 32'(want.irq_assert), 32'(i_irq_assert));
                    check_field("firq_assert", 32'(want.firq_assert), 32'(i_firq_assert));
                    check_field("timer_load", 32'(want.timer_load), 32'(i_timer_load));
                    check_field("timer_value", 32'(want.timer_value), 32'(i_timer_value));
                    check_field("source_enable", 32'(want.source_enable),
                                32'(i_source_enable));
                end
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(steer_request(t_req'(i_req_type), i_reg_address,
                                                    i_write_data, t_src'(i_event_source)));
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== tb/sv/tb_interrupt_steering_register_file_core.sv =====
`timescale 1ns / 100ps

module tb_interrupt_steering_register_file_core;
    import isrf_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int HOLD_AT_ITEM = 900;
    localparam int HOLD_CYCLES  = 250;
    localparam int TIMEOUT_NS   = 12 * 300000;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic [1:0]           i_req_type     = REQ_IDLE;
    logic [ADDR_W-1:0]    i_reg_address  = '0;
    logic [DATA_W-1:0]    i_write_data   = '0;
    logic [1:0]           i_event_source = SRC_KEYBOARD;
    logic                 i_out_ready    = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [DATA_W-1:0]    o_read_data;
    logic                 o_irq_assert;
    logic                 o_firq_assert;
    logic                 o_timer_load;
    logic [TIMER_W-1:0]   o_timer_value;
    logic [SRC_N-1:0]     o_source_enable;

    int          fail_count;
    int          pending_count;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_off      = 1'b0;
    int          items_sent    = 0;

    interrupt_steering_register_file_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_reg_address   (i_reg_address),
        .i_write_data    (i_write_data),
        .i_event_source  (i_event_source),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_irq_assert    (o_irq_assert),
        .o_firq_assert   (o_firq_assert),
        .o_timer_load    (o_timer_load),
        .o_timer_value   (o_timer_value),
        .o_source_enable (o_source_enable)
    );

    interrupt_steering_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_reg_address   (i_reg_address),
        .i_write_data    (i_write_data),
        .i_event_source  (i_event_source),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_read_data     (o_read_data),
        .i_irq_assert    (o_irq_assert),
        .i_firq_assert   (o_firq_assert),
        .i_timer_load    (o_timer_load),
        .i_timer_value   (o_timer_value),
        .i_source_enable (o_source_enable),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver stalls at random, and all the time during the hold-off.
    always @(posedge i_clk) begin
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off while the sender keeps pushing requests.
    initial begin
        wait (items_sent == HOLD_AT_ITEM);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Offer one request, after a random gap, and wait until it is taken.
    task automatic issue_request(input t_req req, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] data, input t_src src);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_reg_address  <= addr;
        i_write_data   <= data;
        i_event_source <= src;
        do @(posedge i_clk); while (!o_in_ready);
        if (req != REQ_IDLE) begin
            items_sent++;
        end
    endtask

    // Random request, with addresses drawn mostly from the interrupt and
    // timer registers so that routing and latches see real traffic.
    task automatic issue_random_request();
        int unsigned       pick;
        logic [ADDR_W-1:0] addr;
        t_req              req;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 55) begin
            addr = 8'($urandom_range(ADDR_TIMER_LSB, ADDR_INIT0));
        end else begin
            addr = 8'($urandom);
        end
        if (pick < 5) begin
            req = REQ_IDLE;
        end else if (pick < 35) begin
            req = REQ_READ;
        end else if (pick < 65) begin
            req = REQ_WRITE;
        end else begin
            req = REQ_EVENT;
        end
        issue_request(req, addr, 8'($urandom), t_src'($urandom_range(3)));
    endtask

    initial begin
        int target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 55;

        // Reset values, fixed readback of the timer registers, empty latches.
        issue_request(REQ_READ, 8'h00, 8'hFF, SRC_TIMER);
        issue_request(REQ_READ, ADDR_IRQ_EN, 8'h00, SRC_KEYBOARD);
        issue_request(REQ_READ, ADDR_FIRQ_EN, 8'h00, SRC_KEYBOARD);
        issue_request(REQ_READ, ADDR_TIMER_MSB, 8'h00, SRC_KEYBOARD);
        issue_request(REQ_READ, ADDR_TIMER_LSB, 8'h00, SRC_KEYBOARD);
        // Extremes of address and data.
        issue_request(REQ_WRITE, 8'hFF, 8'hFF, SRC_TIMER);
        issue_request(REQ_READ, 8'hFF, 8'h00, SRC_KEYBOARD);
        issue_request(REQ_WRITE, 8'h00, 8'h00, SRC_KEYBOARD);
        // An event with nothing enabled goes nowhere; address and data ignored.
        issue_request(REQ_EVENT, 8'h90, 8'hFF, SRC_KEYBOARD);
        // The unused request code must not touch the flags.
        issue_request(REQ_IDLE, ADDR_INIT0, 8'hFF, SRC_TIMER);
        // Normal line: all sources enabled in the IRQ register.
        issue_request(REQ_WRITE, ADDR_IRQ_EN, 8'h3A, SRC_KEYBOARD);
        issue_request(REQ_WRITE, ADDR_INIT0, 8'h20, SRC_KEYBOARD);
        issue_request(REQ_EVENT, 8'h00, 8'h00, SRC_VERTICAL);
        issue_request(REQ_READ, ADDR_IRQ_EN, 8'h00, SRC_KEYBOARD);
        // Fast line takes precedence where both routes are open.
        issue_request(REQ_WRITE, ADDR_FIRQ_EN, 8'h22, SRC_KEYBOARD);
        issue_request(REQ_WRITE, ADDR_INIT0, 8'h30, SRC_KEYBOARD);
        issue_request(REQ_EVENT, 8'h00, 8'h00, SRC_TIMER);
        issue_request(REQ_EVENT, 8'h00, 8'h00, SRC_KEYBOARD);
        issue_request(REQ_EVENT, 8'h00, 8'h00, SRC_HORIZONTAL);
        issue_request(REQ_READ, ADDR_FIRQ_EN, 8'h00, SRC_KEYBOARD);
        issue_request(REQ_READ, ADDR_IRQ_EN, 8'h00, SRC_KEYBOARD);
        // Timer reload, all bits and no bits of the high byte.
        issue_request(REQ_WRITE, ADDR_TIMER_LSB, 8'hAB, SRC_KEYBOARD);
        issue_request(REQ_WRITE, ADDR_TIMER_MSB, 8'hFF, SRC_KEYBOARD);
        issue_request(REQ_WRITE, ADDR_TIMER_MSB, 8'h00, SRC_KEYBOARD);
        // Enhanced IRQ off: an event enabled only for IRQ is dropped.
        issue_request(REQ_WRITE, ADDR_INIT0, 8'h10, SRC_KEYBOARD);
        issue_request(REQ_EVENT, 8'hFF, 8'hFF, SRC_VERTICAL);

        // Random requests in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < target) begin
                issue_random_request();
            end
        end
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then allow for the pipeline latency.
        do @(posedge i_clk); while (pending_count != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
